// ===== rtl/lgwp_pkg.sv =====
// Shared types and constants of the largest gap window placer.
package lgwp_pkg;

   localparam int WINDOW_SLOTS = 64;
   localparam int IDX_W = $clog2(WINDOW_SLOTS);
   localparam int COUNT_W = $clog2(WINDOW_SLOTS + 1);
   localparam int ADDR_W = 32;
   localparam int COUNT_FIELD_W = 7;
   localparam int CSR_INDEX_W = 1;

   localparam logic [ADDR_W-1:0] ZONE_START_RESET = 32'hE000_0000;
   localparam logic [ADDR_W-1:0] MIN_GAP_RESET = 32'h0100_0000;
   localparam logic [ADDR_W-1:0] ALIGN_MASK = ~32'h0000_0FFF;
   localparam logic [7:0] BRIDGE_CLASS = 8'h06;
   localparam logic [7:0] SUB_PCI_PCI = 8'h04;
   localparam logic [7:0] SUB_CARDBUS = 8'h07;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_FIND = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ZONE_START = 1'd0,
      CSR_MIN_GAP = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [ADDR_W-1:0] window_base;
      logic is_io_window;
      logic [7:0] device_class;
      logic [7:0] device_subclass;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] placed_base;
      logic found;
      logic accepted;
      logic [COUNT_FIELD_W-1:0] window_count;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] zone_start;
      logic [ADDR_W-1:0] minimum_gap;
   } cfg_type;

   // handshake between the top level and the core
   typedef struct packed {
      logic start;
      logic take;
   } core_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_status_type;

endpackage

// ===== rtl/lgwp_core.sv =====
// Window table memory with sorted insertion on record, a gap scan on find and a count reset on clear.
module lgwp_core (
   input  logic                     clock,
   input  logic                     reset,
   input  lgwp_pkg::core_ctrl_type   ctrl,
   input  lgwp_pkg::req_type         item,
   input  lgwp_pkg::cfg_type         cfg,
   output lgwp_pkg::core_status_type status,
   output lgwp_pkg::rsp_type         result
);

   typedef enum logic [5:0] {
      ST_IDLE        = 6'b000001,
      ST_INSERT      = 6'b000010,
      ST_INSERT_LAST = 6'b000100,
      ST_SCAN        = 6'b001000,
      ST_FINISH      = 6'b010000,
      ST_DONE        = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [lgwp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [lgwp_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [lgwp_pkg::ADDR_W-1:0] value_ff, value_in;
   logic [lgwp_pkg::ADDR_W-1:0] edge_ff, edge_in;
   logic [lgwp_pkg::ADDR_W-1:0] best_w_ff, best_w_in;
   logic [lgwp_pkg::ADDR_W-1:0] best_s_ff, best_s_in;
   lgwp_pkg::rsp_type res_ff, res_in;

   logic [lgwp_pkg::ADDR_W-1:0] table_mem [lgwp_pkg::WINDOW_SLOTS];
   logic [lgwp_pkg::ADDR_W-1:0] rd_data_ff;
   logic rd_en, wr_en;
   logic [lgwp_pkg::IDX_W-1:0] rd_addr, wr_addr;
   logic [lgwp_pkg::ADDR_W-1:0] wr_data;

   logic skip;
   logic [lgwp_pkg::COUNT_W-1:0] count_m1, count_p1;
   logic [lgwp_pkg::ADDR_W-1:0] gap;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign skip = (item.window_base == '0) || item.is_io_window ||
                 ((item.device_class == lgwp_pkg::BRIDGE_CLASS) &&
                  ((item.device_subclass == lgwp_pkg::SUB_CARDBUS) ||
                   (item.device_subclass == lgwp_pkg::SUB_PCI_PCI)));
   assign count_m1 = count_ff - 1'b1;
   assign count_p1 = count_ff + 1'b1;
   assign gap = rd_data_ff - edge_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      value_in = value_ff;
      edge_in = edge_ff;
      best_w_in = best_w_ff;
      best_s_in = best_s_ff;
      res_in = res_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = value_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               res_in = '0;
               res_in.window_count = lgwp_pkg::COUNT_FIELD_W'(count_ff);
               state_in = ST_DONE;
               case (item.opcode)
                  lgwp_pkg::OP_RECORD: begin
                     if (!skip && (count_ff < lgwp_pkg::COUNT_W'(lgwp_pkg::WINDOW_SLOTS))) begin
                        if (count_ff == '0) begin
                           wr_en = 1'b1;
                           wr_addr = '0;
                           wr_data = item.window_base;
                           count_in = count_p1;
                           res_in.accepted = 1'b1;
                           res_in.window_count = lgwp_pkg::COUNT_FIELD_W'(count_p1);
                        end else begin
                           // walk down from the top entry, shifting larger bases up
                           rd_en = 1'b1;
                           rd_addr = count_m1[lgwp_pkg::IDX_W-1:0];
                           idx_in = count_m1[lgwp_pkg::IDX_W-1:0];
                           value_in = item.window_base;
                           state_in = ST_INSERT;
                        end
                     end
                  end
                  lgwp_pkg::OP_FIND: begin
                     if (count_ff != '0) begin
                        rd_en = 1'b1;
                        rd_addr = '0;
                        idx_in = '0;
                        edge_in = cfg.zone_start;
                        best_w_in = '0;
                        best_s_in = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  lgwp_pkg::OP_CLEAR: begin
                     count_in = '0;
                     res_in.window_count = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INSERT: begin
            wr_en = 1'b1;
            wr_addr = idx_ff + 1'b1;
            if (rd_data_ff > value_ff) begin
               wr_data = rd_data_ff;
               if (idx_ff == '0) begin
                  state_in = ST_INSERT_LAST;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = idx_ff - 1'b1;
                  idx_in = idx_ff - 1'b1;
               end
            end else begin
               wr_data = value_ff;
               count_in = count_p1;
               res_in.accepted = 1'b1;
               res_in.window_count = lgwp_pkg::COUNT_FIELD_W'(count_p1);
               state_in = ST_DONE;
            end
         end
         ST_INSERT_LAST: begin
            wr_en = 1'b1;
            wr_addr = '0;
            wr_data = value_ff;
            count_in = count_p1;
            res_in.accepted = 1'b1;
            res_in.window_count = lgwp_pkg::COUNT_FIELD_W'(count_p1);
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // only gaps closed above by a base count; first widest wins
            if ((rd_data_ff > edge_ff) && (gap > best_w_ff)) begin
               best_w_in = gap;
               best_s_in = edge_ff;
            end
            if (rd_data_ff >= edge_ff) begin
               edge_in = rd_data_ff;
            end
            if (idx_ff == count_m1[lgwp_pkg::IDX_W-1:0]) begin
               state_in = ST_FINISH;
            end else begin
               rd_en = 1'b1;
               rd_addr = idx_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if ((best_w_ff != '0) && (best_w_ff >= cfg.minimum_gap)) begin
               res_in.found = 1'b1;
               res_in.placed_base = (best_s_ff + (best_w_ff >> 1)) & lgwp_pkg::ALIGN_MASK;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctrl.take) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      value_ff <= value_in;
      edge_ff <= edge_in;
      best_w_ff <= best_w_in;
      best_s_ff <= best_s_in;
      res_ff <= res_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign result = res_ff;

endmodule

// ===== rtl/largest_gap_window_placer.sv =====
// Top level: request channel, control registers and result register around the core.
// Clear, find on an empty table and a dropped record go from idle straight to done in the core.
// A stored record on an empty table is written at once, else larger bases shift up; find reads each stored window.
// Both walk the table memory, one entry read per cycle through its read port.
// One request at a time: the next is taken in the cycle after the result leaves the core.
// Reset (synchronous): table empty, zone_start and minimum_gap at reset values.
module largest_gap_window_placer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lgwp_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lgwp_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lgwp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lgwp_pkg::ADDR_W-1:0]          csr_data
);

   lgwp_pkg::cfg_type cfg_ff, cfg_in;
   logic rsp_valid_ff, rsp_valid_in;
   lgwp_pkg::rsp_type rsp_payload_ff, rsp_payload_in;
   lgwp_pkg::core_ctrl_type ctrl;
   lgwp_pkg::core_status_type status;
   lgwp_pkg::rsp_type core_result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lgwp_pkg::CSR_ZONE_START: cfg_in.zone_start = csr_data;
            lgwp_pkg::CSR_MIN_GAP: cfg_in.minimum_gap = csr_data;
         endcase
      end
   end

   assign req_stall = !status.idle;
   assign ctrl.start = req_valid && status.idle;
   // result register frees when empty or being taken this cycle
   assign ctrl.take = status.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (ctrl.take) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zone_start <= lgwp_pkg::ZONE_START_RESET;
         cfg_ff.minimum_gap <= lgwp_pkg::MIN_GAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   lgwp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .item   (req_payload),
      .cfg    (cfg_ff),
      .status (status),
      .result (core_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/lgwp_checker.sv =====
// Port-level checks for the window placer, bound to the top level.
module lgwp_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input lgwp_pkg::rsp_type    rsp_payload
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // one request at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.found |-> rsp_payload.placed_base[11:0] == 12'h000)
      else $error("placed base not 4 KB aligned");

   a_record_no_place: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.accepted || !rsp_payload.found)
         |-> !(rsp_payload.accepted && rsp_payload.found) &&
             (rsp_payload.found || rsp_payload.placed_base == '0))
      else $error("placement on a non-find result");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.window_count <= lgwp_pkg::COUNT_FIELD_W'(lgwp_pkg::WINDOW_SLOTS))
      else $error("window count beyond table size");

endmodule

bind largest_gap_window_placer lgwp_checker u_lgwp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
